>>> rtl/tbrl_pkg.sv
package tbrl_pkg;

    localparam int TS_W      = 63;
    localparam int REQ_W     = 16;
    localparam int CAP_W     = 16;
    localparam int RATE_W    = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 20;

    localparam int unsigned DEF_SCALE  = 1_000_000;
    localparam int unsigned CAP_RESET  = 5;
    localparam int unsigned RATE_RESET = 10;

    localparam longint unsigned NS_PER_SEC = 64'd1_000_000_000;

    // remainder width covers both divisors (1e9 and the scale)
    localparam int REM_W     = $clog2(NS_PER_SEC);
    localparam int HALF_W    = 32;
    localparam int PP_N      = 4;
    localparam int DIV_RADIX = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE     = 1'd1;

    typedef struct packed {
        logic       accept;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_en;
        logic       chk;
        logic       div_step;
        logic       upd;
        logic       ded;
        logic       tok_load;
    } tbrl_cmd_t;

    typedef struct packed {
        logic advance;
        logic saturated;
    } tbrl_sts_t;

    function automatic int div_iters(int unsigned scale);
        int lw;
        lw = CAP_W + $clog2(scale + 1);
        return (lw + DIV_RADIX - 1) / DIV_RADIX;
    endfunction

endpackage

>>> rtl/tbrl_req_if.sv
interface tbrl_req_if import tbrl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TS_W-1:0]  timestamp_ns;
    logic [REQ_W-1:0] request_count;

    modport source (output valid, timestamp_ns, request_count, input ready);
    modport sink   (input valid, timestamp_ns, request_count, output ready);
endinterface

>>> rtl/tbrl_rsp_if.sv
interface tbrl_rsp_if import tbrl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             granted;
    logic [REQ_W-1:0] tokens_available;

    modport source (output valid, granted, tokens_available, input ready);
    modport sink   (input valid, granted, tokens_available, output ready);
endinterface

>>> rtl/tbrl_cfg_if.sv
interface tbrl_cfg_if import tbrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tbrl_ctrl.sv
module tbrl_ctrl import tbrl_pkg::*; #(
    parameter int unsigned TOKEN_FRACTION_SCALE = DEF_SCALE
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  tbrl_sts_t sts,
    output tbrl_cmd_t cmd
);

    localparam int ITERS     = div_iters(TOKEN_FRACTION_SCALE);
    localparam int TOK_ITERS = REQ_W / DIV_RADIX;
    localparam int CNT_MAX   = (ITERS > PP_N) ? ITERS : PP_N;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIVG = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_DED  = 4'd5;
    localparam logic [3:0] S_TOK  = 4'd6;
    localparam logic [3:0] S_DIVT = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                cnt_next  = '0;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.advance ? S_MUL : S_DED;
                end
            end
            S_MUL:
            begin
                // product k is formed at step k and summed at step k+1
                cmd.mul_en  = (cnt_reg != CNT_W'(PP_N));
                cmd.mul_sel = cnt_reg[1:0];
                cmd.acc_en  = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(PP_N))
                begin
                    cnt_next   = '0;
                    state_next = S_CHK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CHK:
            begin
                cmd.chk    = 1'b1;
                cnt_next   = '0;
                state_next = sts.saturated ? S_DED : S_DIVG;
            end
            S_DIVG:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(ITERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DED;
            end
            S_DED:
            begin
                cmd.ded    = 1'b1;
                state_next = S_TOK;
            end
            S_TOK:
            begin
                cmd.tok_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIVT;
            end
            S_DIVT:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(TOK_ITERS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/tbrl_datapath.sv
module tbrl_datapath import tbrl_pkg::*; #(
    parameter int unsigned TOKEN_FRACTION_SCALE = DEF_SCALE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbrl_cmd_t            cmd,
    output tbrl_sts_t            sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [TS_W-1:0]      timestamp_ns,
    input  logic [REQ_W-1:0]     request_count,
    output logic                 granted,
    output logic [REQ_W-1:0]     tokens_available
);

    localparam int SW      = $clog2(TOKEN_FRACTION_SCALE + 1);
    localparam int LW      = CAP_W + SW;
    localparam int RS_W    = RATE_W + SW;
    localparam int PW      = TS_W + RS_W;
    localparam int QW      = div_iters(TOKEN_FRACTION_SCALE) * DIV_RADIX;
    localparam int MW      = 2 * HALF_W;
    localparam int WIDE_W  = 2 * MW;

    localparam logic [PW-1:0]    SAT_LIM    = PW'(NS_PER_SEC) << LW;
    localparam logic [LW-1:0]    FULL_RESET =
        LW'(64'(CAP_RESET) * 64'(TOKEN_FRACTION_SCALE));
    localparam logic [RS_W-1:0]  RS_RESET   =
        RS_W'(64'(RATE_RESET) * 64'(TOKEN_FRACTION_SCALE));
    localparam logic [REM_W-1:0] DIV_NS     = REM_W'(NS_PER_SEC);
    localparam logic [REM_W-1:0] DIV_SCALE  = REM_W'(TOKEN_FRACTION_SCALE);

    // bucket state
    logic [LW-1:0]   level_reg;
    logic [LW-1:0]   full_reg;
    logic [RS_W-1:0] rs_reg;
    logic [TS_W-1:0] last_reg;

    // per-item working registers
    logic [TS_W-1:0]  ts_reg;
    logic [TS_W-1:0]  elapsed_reg;
    logic [LW-1:0]    needed_reg;
    logic [PW-1:0]    acc_reg;
    logic [MW-1:0]    pp_reg;
    logic [1:0]       pp_sel_reg;
    logic [REM_W-1:0] rem_reg;
    logic [QW-1:0]    nq_reg;
    logic [REM_W-1:0] div_reg;
    logic             granted_reg;

    logic [MW-1:0]     e_ext;
    logic [MW-1:0]     rs_ext;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [MW-1:0]     pp_next;
    logic [WIDE_W-1:0] pp_wide;
    logic [PW-1:0]     acc_add;
    logic [REM_W-1:0]  rem_step;
    logic [QW-1:0]     nq_step;
    logic [LW:0]       refill_sum;
    logic [LW-1:0]     full_wr;
    logic [RS_W-1:0]   rs_wr;

    assign e_ext   = MW'(elapsed_reg);
    assign rs_ext  = MW'(rs_reg);
    assign mul_a   = cmd.mul_sel[0] ? e_ext[MW-1:HALF_W] : e_ext[HALF_W-1:0];
    assign mul_b   = cmd.mul_sel[1] ? rs_ext[MW-1:HALF_W] : rs_ext[HALF_W-1:0];
    assign pp_next = MW'(mul_a) * MW'(mul_b);

    always_comb
    begin
        pp_wide = WIDE_W'(pp_reg);
        if (pp_sel_reg[0])
        begin
            pp_wide = pp_wide << HALF_W;
        end
        if (pp_sel_reg[1])
        begin
            pp_wide = pp_wide << HALF_W;
        end
    end

    assign acc_add = acc_reg + pp_wide[PW-1:0];

    // restoring division, DIV_RADIX quotient bits per cycle
    always_comb
    begin
        logic [REM_W:0] r_t;
        logic [QW-1:0]  q_t;
        r_t = {1'b0, rem_reg};
        q_t = nq_reg;
        for (int j = 0; j < DIV_RADIX; j++)
        begin
            r_t = {r_t[REM_W-1:0], q_t[QW-1]};
            q_t = {q_t[QW-2:0], 1'b0};
            if (r_t >= {1'b0, div_reg})
            begin
                r_t    = r_t - {1'b0, div_reg};
                q_t[0] = 1'b1;
            end
        end
        rem_step = r_t[REM_W-1:0];
        nq_step  = q_t;
    end

    assign refill_sum = {1'b0, level_reg} + {1'b0, nq_reg[LW-1:0]};
    assign full_wr    = LW'(cfg_data[CAP_W-1:0]) * LW'(TOKEN_FRACTION_SCALE);
    assign rs_wr      = RS_W'(cfg_data[RATE_W-1:0]) * RS_W'(TOKEN_FRACTION_SCALE);

    assign sts.advance   = (timestamp_ns > last_reg);
    assign sts.saturated = (acc_reg >= SAT_LIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= FULL_RESET;
            full_reg  <= FULL_RESET;
            rs_reg    <= RS_RESET;
            last_reg  <= '0;
        end
        else
        begin
            if (cmd.chk)
            begin
                last_reg <= ts_reg;
                if (sts.saturated)
                begin
                    level_reg <= full_reg;
                end
            end
            if (cmd.upd)
            begin
                level_reg <= (refill_sum >= {1'b0, full_reg}) ? full_reg
                                                               : refill_sum[LW-1:0];
            end
            if (cmd.ded && (level_reg >= needed_reg))
            begin
                level_reg <= level_reg - needed_reg;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAPACITY:
                    begin
                        full_reg  <= full_wr;
                        level_reg <= full_wr;
                    end
                    REG_RATE:
                    begin
                        rs_reg <= rs_wr;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ts_reg      <= timestamp_ns;
            elapsed_reg <= timestamp_ns - last_reg;
            needed_reg  <= LW'(request_count) * LW'(TOKEN_FRACTION_SCALE);
            acc_reg     <= '0;
        end
        if (cmd.mul_en)
        begin
            pp_reg     <= pp_next;
            pp_sel_reg <= cmd.mul_sel;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_add;
        end
        if (cmd.chk)
        begin
            rem_reg <= REM_W'(acc_reg >> QW);
            nq_reg  <= acc_reg[QW-1:0];
            div_reg <= DIV_NS;
        end
        if (cmd.tok_load)
        begin
            rem_reg <= REM_W'(level_reg >> REQ_W);
            nq_reg  <= QW'(level_reg[REQ_W-1:0]) << (QW - REQ_W);
            div_reg <= DIV_SCALE;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            nq_reg  <= nq_step;
        end
        if (cmd.ded)
        begin
            granted_reg <= (level_reg >= needed_reg);
        end
    end

    assign granted          = granted_reg;
    assign tokens_available = nq_reg[REQ_W-1:0];

endmodule

>>> rtl/token_bucket_rate_limiter.sv
// Per item: if time advances, the elapsed x rate product, then, unless it overflows the level,
// the 1e9 divide and the capped refill (else the bucket is set full); then deduction and readout.
// One item at a time: the next item is taken the cycle after the result is taken.
// The steps use the shared 32x32 multiplier (four partial products of elapsed x rate)
// and the 8-bit-per-cycle divider used for the 1e9 refill divide and the token readout.
// rst_n (async, active low): bucket full at 5 tokens, rate 10 per second, last time zero.
module token_bucket_rate_limiter import tbrl_pkg::*; #(
    parameter int unsigned TOKEN_FRACTION_SCALE = DEF_SCALE
) (
    input logic        clk,
    input logic        rst_n,
    tbrl_req_if.sink   req,
    tbrl_rsp_if.source rsp,
    tbrl_cfg_if.sink   cfg
);

    tbrl_cmd_t cmd;
    tbrl_sts_t sts;

    assign cfg.ready = 1'b1;

    tbrl_ctrl #(
        .TOKEN_FRACTION_SCALE(TOKEN_FRACTION_SCALE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tbrl_datapath #(
        .TOKEN_FRACTION_SCALE(TOKEN_FRACTION_SCALE)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg.valid),
        .cfg_index        (cfg.index),
        .cfg_data         (cfg.data),
        .timestamp_ns     (req.timestamp_ns),
        .request_count    (req.request_count),
        .granted          (rsp.granted),
        .tokens_available (rsp.tokens_available)
    );

endmodule

>>> rtl/tbrl_checker.sv
module tbrl_checker import tbrl_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_granted,
    input logic [REQ_W-1:0] rsp_tokens
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_granted) && $stable(rsp_tokens))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second item taken while one is in flight");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("new item offered before result taken");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("result item repeated");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_granted (rsp.granted),
    .rsp_tokens  (rsp.tokens_available)
);
